// ----- design/prq_pkg.sv -----
// Shared types and constants for the priority ready queue.
package prq_pkg;

  // Default number of queue slots
  localparam int QUEUE_DEPTH_DEF = 64;

  // Request outcome codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // One queue slot
  typedef struct packed {
    logic [7:0] thread;
    logic [7:0] prio;
  } entry_t;

  // Result of one request, handed from the sequencer to the output register
  typedef struct packed {
    status_t    status;
    logic [7:0] head_thread;
    logic       head_changed;
    logic       may_run;
    logic [6:0] fill_count;
  } result_t;

endpackage

// ----- design/priority_ready_queue.sv -----
// Top level of the priority ready queue with its result register.
//
// Keeps up to QUEUE_DEPTH thread ids ordered by priority (lower value first,
// equal priorities in arrival order) in a single-port-write, registered-read
// slot memory walked by one sequencer. A request for a nonzero thread id first
// walks forward over all queued slots. An insert then walks backward from the
// tail to the insert point to open a gap and writes the new slot; an insert
// finds at most 63 threads queued at the default depth of 64. A removal closes
// the gap during its forward walk. The next request can be taken in the cycle
// after the result is loaded. While the output register holds a stalled
// result, a finished request waits in its final state. One slot is read per
// cycle during a walk. No clearing pass is needed after reset: only slots
// below the fill count are ever read. The result sits in an output register,
// so the next request is taken while it waits.
module priority_ready_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] thread_id,
  input  logic       work_done,
  input  logic [7:0] priority_req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [2:0] status,
  output logic [7:0] head_thread,
  output logic       head_changed,
  output logic       may_run,
  output logic [6:0] fill_count
);
  import prq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          busy;
  logic          done;
  logic          rsp_free;
  result_t       res;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  result_t       rsp;

  assign req_stall = busy;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  prq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (req_valid && !busy),
    .thread_id    (thread_id),
    .work_done    (work_done),
    .priority_req (priority_req),
    .busy         (busy),
    .done         (done),
    .take         (rsp_free),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  prq_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Hold the result until taken, load the next one when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= done;
      if (done) begin
        rsp <= res;
      end
    end
  end

  assign status       = rsp.status;
  assign head_thread  = rsp.head_thread;
  assign head_changed = rsp.head_changed;
  assign may_run      = rsp.may_run;
  assign fill_count   = rsp.fill_count;

endmodule

// ----- design/prq_ram.sv -----
// Slot memory: one write port, one registered read port.
module prq_ram #(
  parameter int QUEUE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output prq_pkg::entry_t        rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  prq_pkg::entry_t        wr_data
);
  import prq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  // Write the slot and register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/prq_ctrl.sv -----
// Sequencer that walks the slot memory to search, insert and remove threads.
module prq_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        thread_id,
  input  logic              work_done,
  input  logic [7:0]        priority_req,
  output logic              busy,
  output logic              done,
  input  logic              take,
  output prq_pkg::result_t  res,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  prq_pkg::entry_t   rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output prq_pkg::entry_t   wr_data
);
  import prq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_FIN
  } state_t;

  state_t        state;
  logic [7:0]    tid;
  logic [7:0]    prio;
  logic          remove;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos;
  logic          found;
  logic          pos_found;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] occ;
  logic [7:0]    head;
  status_t       status;
  logic          changed;

  logic          scan_issue;
  logic          shift_issue;
  logic [CW-1:0] ptr_m1;
  logic          match;
  logic [CW+6:0] occ_ext;

  // Read issue: forward walk while scanning, backward walk while shifting
  assign scan_issue  = (state == S_SCAN) && (ptr < occ);
  assign shift_issue = (state == S_SHIFT) && (ptr > pos);
  assign ptr_m1      = ptr - CW'(1);
  assign rd_en       = scan_issue || shift_issue;
  assign rd_addr     = scan_issue ? ptr[AW-1:0] : ptr_m1[AW-1:0];
  assign match       = (rd_data.thread == tid);

  // Slot writes: close the gap on removal, open it on insert, then place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    case (state)
      S_SCAN: begin
        if (rd_vld && remove && found) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - AW'(1);
        end
      end
      S_SHIFT: begin
        if (rd_vld) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + AW'(1);
        end
      end
      S_PLACE: begin
        wr_en        = 1'b1;
        wr_addr      = pos[AW-1:0];
        wr_data.thread = tid;
        wr_data.prio   = prio;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign busy    = (state != S_IDLE);
  assign done    = (state == S_FIN);
  assign occ_ext = {7'b0, occ};

  // Result as seen after the step
  always_comb begin
    res.status       = status;
    res.head_thread  = head;
    res.head_changed = changed;
    res.may_run      = (tid != 8'd0) && (head == tid);
    res.fill_count   = occ_ext[6:0];
  end

  // Sequence one request
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      occ    <= '0;
      head   <= 8'd0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        rd_idx <= rd_addr;
      end
      // Track the front slot from every write to it
      if (wr_en && (wr_addr == '0)) begin
        head <= wr_data.thread;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            tid       <= thread_id;
            prio      <= priority_req;
            remove    <= work_done;
            ptr       <= '0;
            found     <= 1'b0;
            pos_found <= 1'b0;
            changed   <= 1'b0;
            if (thread_id == 8'd0) begin
              status <= ST_NOTFOUND;
              state  <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            ptr <= ptr + CW'(1);
          end
          // Compare the returned slot
          if (rd_vld) begin
            if (match) begin
              found <= 1'b1;
            end
            if (remove) begin
              if (match) begin
                pos <= CW'(rd_idx);
              end
            end else if (!pos_found && (rd_data.prio > prio)) begin
              pos       <= CW'(rd_idx);
              pos_found <= 1'b1;
            end
          end
          // Decide once the walk has drained
          if (!scan_issue && !rd_vld) begin
            if (remove) begin
              state <= S_FIN;
              if (found) begin
                status <= ST_REMOVED;
                occ    <= occ - CW'(1);
                if (occ == CW'(1)) begin
                  head <= 8'd0;
                end
              end else begin
                status <= ST_NOTFOUND;
              end
            end else if (found) begin
              status <= ST_PRESENT;
              state  <= S_FIN;
            end else if (occ == CW'(QUEUE_DEPTH)) begin
              status <= ST_FULL;
              state  <= S_FIN;
            end else begin
              ptr   <= occ;
              state <= S_SHIFT;
              if (!pos_found) begin
                pos <= occ;
              end
            end
          end
        end
        S_SHIFT: begin
          if (shift_issue) begin
            ptr <= ptr_m1;
          end
          if (!shift_issue && !rd_vld) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          changed <= (pos == '0) && (occ != '0);
          occ     <= occ + CW'(1);
          status  <= ST_INSERTED;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Slot memory is never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("slot write while idle");

  // An empty queue has no head and a non-empty one always has one
  a_head_occ: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) == (head == 8'd0))
    else $error("head and occupancy disagree");

  // Occupancy stays within the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  // Read data returns only while walking the slots
  a_rd_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_SCAN || state == S_SHIFT))
    else $error("read data outside a walk");

  // Writes land inside the occupied range plus one
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) <= occ))
    else $error("slot write beyond the queue tail");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the priority ready queue.
`timescale 1ns / 100ps

module tb;
  import prq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_IDLE = 17;

  typedef struct {
    logic [7:0]  tid;
    logic        done;
    logic [7:0]  prio;
    int unsigned gap;
  } req_item_t;

  typedef struct {
    status_t    status;
    logic [7:0] head;
    logic       changed;
    logic       run;
    logic [6:0] fill;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [7:0] thread_id = 8'd0;
  logic       work_done = 1'b0;
  logic [7:0] priority_req = 8'd0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] head_thread;
  logic       head_changed;
  logic       may_run;
  logic [6:0] fill_count;

  // Items waiting to be driven and results waiting to arrive
  req_item_t     request_queue[$];
  sched_result_t expected_results[$];

  // Shadow of the ready queue used for prediction
  logic [7:0] q_thread[DEPTH];
  logic [7:0] q_prio[DEPTH];
  int         q_count = 0;

  // Membership view used while building the stimulus
  bit         tracked[256];
  logic [7:0] tracked_ids[$];
  bit         quiet_gaps = 1'b0;

  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_count = 0;
  int unsigned stall_left = 0;
  int unsigned calm_results = 0;
  req_item_t   next_req;
  sched_result_t got;

  priority_ready_queue uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .thread_id    (thread_id),
    .work_done    (work_done),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .head_thread  (head_thread),
    .head_changed (head_changed),
    .may_run      (may_run),
    .fill_count   (fill_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the shadow queue and return the result it yields
  function automatic sched_result_t schedule_request(logic [7:0] tid, logic done,
                                                     logic [7:0] prio);
    sched_result_t r;
    int found;
    int pos;
    int i;
    r.changed = 1'b0;
    found = -1;
    for (i = 0; i < q_count; i++) begin
      if (found < 0 && q_thread[i] == tid) found = i;
    end
    if (tid == 8'd0) begin
      r.status = ST_NOTFOUND;
    end else if (!done) begin
      if (found >= 0) begin
        r.status = ST_PRESENT;
      end else if (q_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // place behind every entry of equal or more urgent priority
        pos = 0;
        while (pos < q_count && q_prio[pos] <= prio) pos++;
        for (i = q_count; i > pos; i--) begin
          q_thread[i] = q_thread[i-1];
          q_prio[i] = q_prio[i-1];
        end
        q_thread[pos] = tid;
        q_prio[pos] = prio;
        if (pos == 0 && q_count > 0) r.changed = 1'b1;
        q_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (found < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        // close the gap left by the removed thread
        for (i = found; i + 1 < q_count; i++) begin
          q_thread[i] = q_thread[i+1];
          q_prio[i] = q_prio[i+1];
        end
        q_count--;
        r.status = ST_REMOVED;
      end
    end
    r.head = (q_count > 0) ? q_thread[0] : 8'd0;
    r.run = (tid != 8'd0 && r.head == tid);
    r.fill = q_count[6:0];
    return r;
  endfunction

  // Queue one item and track which threads it leaves in the ready queue
  task automatic enqueue_request(logic [7:0] tid, logic done, logic [7:0] prio);
    req_item_t it;
    int idx;
    it.tid = tid;
    it.done = done;
    it.prio = prio;
    it.gap = quiet_gaps ? 0 : $urandom_range(0, MAX_IDLE);
    request_queue.push_back(it);
    if (tid != 8'd0) begin
      if (!done && !tracked[tid] && tracked_ids.size() < DEPTH) begin
        tracked[tid] = 1'b1;
        tracked_ids.push_back(tid);
      end else if (done && tracked[tid]) begin
        tracked[tid] = 1'b0;
        idx = -1;
        foreach (tracked_ids[k]) if (tracked_ids[k] == tid) idx = k;
        tracked_ids.delete(idx);
      end
    end
  endtask

  function automatic logic [7:0] absent_thread();
    logic [7:0] tid;
    tid = 8'($urandom_range(1, 255));
    while (tracked[tid]) tid = 8'($urandom_range(1, 255));
    return tid;
  endfunction

  function automatic logic [7:0] random_priority();
    // favor a narrow range so that equal priorities meet often
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7));
  endfunction

  // Drive requests; predict each item at the edge it is accepted
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      idle_count = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_results.push_back(schedule_request(thread_id, work_done, priority_req));
      end
      if (!req_valid || !req_stall) begin
        if (request_queue.size() > 0 && idle_count >= request_queue[0].gap) begin
          next_req = request_queue.pop_front();
          thread_id <= next_req.tid;
          work_done <= next_req.done;
          priority_req <= next_req.prio;
          req_valid <= 1'b1;
          idle_count = 0;
        end else begin
          req_valid <= 1'b0;
          idle_count++;
        end
      end
    end
  end

  // Check each accepted result and draw the stall for the next one
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d head=%0d changed=%0d run=%0d fill=%0d",
                   $time, status, head_thread, head_changed, may_run, fill_count);
          error_count++;
        end else begin
          got = expected_results.pop_front();
          if (status !== got.status) begin
            $display("%0t: status expected %0d actual %0d", $time, got.status, status);
            error_count++;
          end
          if (head_thread !== got.head) begin
            $display("%0t: head_thread expected %0d actual %0d", $time, got.head, head_thread);
            error_count++;
          end
          if (head_changed !== got.changed) begin
            $display("%0t: head_changed expected %0d actual %0d",
                     $time, got.changed, head_changed);
            error_count++;
          end
          if (may_run !== got.run) begin
            $display("%0t: may_run expected %0d actual %0d", $time, got.run, may_run);
            error_count++;
          end
          if (fill_count !== got.fill) begin
            $display("%0t: fill_count expected %0d actual %0d", $time, got.fill, fill_count);
            error_count++;
          end
        end
        if (calm_results > 0) begin
          calm_results--;
          stall_left = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) calm_results = $urandom_range(20, 60);
          stall_left = $urandom_range(0, MAX_IDLE);
        end
      end else if (rsp_valid && stall_left > 0) begin
        stall_left--;
      end
      rsp_stall <= (stall_left != 0);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("priority_ready_queue regression: fail");
      $finish;
    end
  end

  initial begin
    int counted;
    int phase_kind;
    int phase_len;
    int roll;
    int n;
    bit do_insert;
    logic [7:0] tid;

    // Directed: ignored id, empty queue, ties, head changes, removals
    enqueue_request(8'd0, 1'b0, 8'd9);
    enqueue_request(8'd0, 1'b1, 8'd255);
    enqueue_request(8'd5, 1'b1, 8'd0);
    enqueue_request(8'd10, 1'b0, 8'd100);
    enqueue_request(8'd255, 1'b0, 8'd255);
    enqueue_request(8'd1, 1'b0, 8'd0);
    enqueue_request(8'd20, 1'b0, 8'd100);
    enqueue_request(8'd10, 1'b0, 8'd3);
    enqueue_request(8'd30, 1'b0, 8'd100);
    enqueue_request(8'd2, 1'b0, 8'd0);
    enqueue_request(8'd1, 1'b1, 8'd170);
    enqueue_request(8'd20, 1'b1, 8'd85);
    enqueue_request(8'd99, 1'b1, 8'd0);
    enqueue_request(8'd255, 1'b1, 8'd0);
    enqueue_request(8'd170, 1'b0, 8'd85);
    enqueue_request(8'd85, 1'b0, 8'd170);
    enqueue_request(8'd128, 1'b0, 8'd128);
    enqueue_request(8'd2, 1'b1, 8'd0);
    enqueue_request(8'd10, 1'b1, 8'd0);
    enqueue_request(8'd30, 1'b1, 8'd0);
    enqueue_request(8'd170, 1'b1, 8'd0);
    enqueue_request(8'd85, 1'b1, 8'd0);
    enqueue_request(8'd128, 1'b1, 8'd0);
    enqueue_request(8'd128, 1'b1, 8'd0);

    // Random: fill, drain and mixed phases with random content
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len = $urandom_range(30, 120);
      quiet_gaps = ($urandom_range(0, 3) == 0);
      for (n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0: do_insert = (roll < 80);
          1: do_insert = (roll < 15);
          default: do_insert = (roll < 50);
        endcase
        if ($urandom_range(0, 49) == 0) begin
          enqueue_request(8'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else if (do_insert) begin
          if ($urandom_range(0, 9) == 0 && tracked_ids.size() > 0)
            tid = tracked_ids[$urandom_range(0, tracked_ids.size() - 1)];
          else
            tid = absent_thread();
          enqueue_request(tid, 1'b0, random_priority());
          counted++;
        end else begin
          if ($urandom_range(0, 9) == 0 || tracked_ids.size() == 0)
            tid = absent_thread();
          else
            tid = tracked_ids[$urandom_range(0, tracked_ids.size() - 1)];
          enqueue_request(tid, 1'b1, 8'($urandom_range(0, 255)));
          counted++;
        end
      end
    end

    // Hold reset, then release
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for all items to be taken and all results to arrive
    @(posedge clk);
    while (request_queue.size() > 0 || req_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("priority_ready_queue regression: pass");
    end else begin
      $display("priority_ready_queue regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/prq_pkg.sv
design/prq_ram.sv
design/prq_ctrl.sv
design/priority_ready_queue.sv
sim/tb.sv
